// File: sv/fcvu_pkg.sv
// fcvu_pkg: shared types, constants and micro-program for the fly camera view update
// no dependencies; imported by the cfg interface, controller, datapath, top level and test

package fcvu_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int TRIG_ITER_DEF   = 16;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOK_SENS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 2'd1;
	localparam logic [15:0] SENS_RESET  = 16'd6554;
	localparam logic [15:0] SPEED_RESET = 16'd640;

	localparam int UNIT_W   = 18;
	localparam int XY_W     = 20;
	localparam int Z_W      = 26;
	localparam int YAW_W    = 25;
	localparam int PITCH_W  = 24;
	localparam int WORK_W   = 34;
	localparam int STEP_W   = 24;
	localparam int CNT_W    = 5;
	localparam int ATAN_W   = 23;
	localparam int WRAP_STEPS = 8;
	localparam int PROG_LEN = 26;

	localparam longint ONE_Q       = 65536;
	localparam longint DEG90       = 90 * ONE_Q;
	localparam longint DEG180      = 180 * ONE_Q;
	localparam longint DEG360      = 360 * ONE_Q;
	localparam longint PITCH_LIM   = 89 * ONE_Q;
	localparam longint CORDIC_GAIN = 39797;
	localparam longint WRAP_BIAS   = 128 * DEG360;

	typedef enum logic [2:0] {
		OP_LOAD, OP_ANGLE, OP_WRAP, OP_CINIT, OP_CITER, OP_CSTORE, OP_PROG, OP_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] idx;
		logic             pitch;
	} cmd_t;

	typedef enum logic [2:0] {A_SY, A_CY, A_STEP, A_EYE0, A_EYE1, A_EYE2} a_sel_t;

	typedef enum logic [3:0] {
		B_CP, B_SP, B_F0, B_F1, B_F2, B_R0, B_R1, B_R2, B_U0, B_U1, B_U2
	} b_sel_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_F0, WB_F2, WB_U0, WB_U2, WB_EYE_ADD, WB_EYE_SUB,
		WB_ACC_LOAD, WB_ACC_ADD, WB_ROW
	} wb_t;

	typedef struct packed {
		a_sel_t     a;
		b_sel_t     b;
		wb_t        wb;
		logic [1:0] lane;
		logic [1:0] key;
	} uop_t;

	// each entry issues one product and retires the product of the entry before
	function automatic uop_t prog_uop(input logic [CNT_W-1:0] idx);
		uop_t u;
		u = '{a: A_SY, b: B_CP, wb: WB_NONE, lane: 2'd0, key: 2'd0};
		case (idx)
			5'd0:  u = '{a: A_CY,   b: B_CP, wb: WB_NONE,     lane: 2'd0, key: 2'd0};
			5'd1:  u = '{a: A_SY,   b: B_CP, wb: WB_F0,       lane: 2'd0, key: 2'd0};
			5'd2:  u = '{a: A_CY,   b: B_SP, wb: WB_F2,       lane: 2'd0, key: 2'd0};
			5'd3:  u = '{a: A_SY,   b: B_SP, wb: WB_U0,       lane: 2'd0, key: 2'd0};
			5'd4:  u = '{a: A_STEP, b: B_F0, wb: WB_U2,       lane: 2'd0, key: 2'd0};
			5'd5:  u = '{a: A_STEP, b: B_F1, wb: WB_EYE_ADD,  lane: 2'd0, key: 2'd0};
			5'd6:  u = '{a: A_STEP, b: B_F2, wb: WB_EYE_ADD,  lane: 2'd1, key: 2'd0};
			5'd7:  u = '{a: A_STEP, b: B_F0, wb: WB_EYE_ADD,  lane: 2'd2, key: 2'd0};
			5'd8:  u = '{a: A_STEP, b: B_F1, wb: WB_EYE_SUB,  lane: 2'd0, key: 2'd1};
			5'd9:  u = '{a: A_STEP, b: B_F2, wb: WB_EYE_SUB,  lane: 2'd1, key: 2'd1};
			5'd10: u = '{a: A_STEP, b: B_R0, wb: WB_EYE_SUB,  lane: 2'd2, key: 2'd1};
			5'd11: u = '{a: A_STEP, b: B_R1, wb: WB_EYE_SUB,  lane: 2'd0, key: 2'd2};
			5'd12: u = '{a: A_STEP, b: B_R2, wb: WB_EYE_SUB,  lane: 2'd1, key: 2'd2};
			5'd13: u = '{a: A_STEP, b: B_R0, wb: WB_EYE_SUB,  lane: 2'd2, key: 2'd2};
			5'd14: u = '{a: A_STEP, b: B_R1, wb: WB_EYE_ADD,  lane: 2'd0, key: 2'd3};
			5'd15: u = '{a: A_STEP, b: B_R2, wb: WB_EYE_ADD,  lane: 2'd1, key: 2'd3};
			5'd16: u = '{a: A_EYE0, b: B_R0, wb: WB_EYE_ADD,  lane: 2'd2, key: 2'd3};
			5'd17: u = '{a: A_EYE1, b: B_R1, wb: WB_ACC_LOAD, lane: 2'd0, key: 2'd0};
			5'd18: u = '{a: A_EYE2, b: B_R2, wb: WB_ACC_ADD,  lane: 2'd0, key: 2'd0};
			5'd19: u = '{a: A_EYE0, b: B_U0, wb: WB_ROW,      lane: 2'd0, key: 2'd0};
			5'd20: u = '{a: A_EYE1, b: B_U1, wb: WB_ACC_LOAD, lane: 2'd0, key: 2'd0};
			5'd21: u = '{a: A_EYE2, b: B_U2, wb: WB_ACC_ADD,  lane: 2'd0, key: 2'd0};
			5'd22: u = '{a: A_EYE0, b: B_F0, wb: WB_ROW,      lane: 2'd1, key: 2'd0};
			5'd23: u = '{a: A_EYE1, b: B_F1, wb: WB_ACC_LOAD, lane: 2'd0, key: 2'd0};
			5'd24: u = '{a: A_EYE2, b: B_F2, wb: WB_ACC_ADD,  lane: 2'd0, key: 2'd0};
			5'd25: u = '{a: A_SY,   b: B_CP, wb: WB_ROW,      lane: 2'd2, key: 2'd0};
			default: u = '{a: A_SY, b: B_CP, wb: WB_NONE,     lane: 2'd0, key: 2'd0};
		endcase
		return u;
	endfunction

	// arctangent of 2^-i in Q16.16 degrees
	function automatic logic [ATAN_W-1:0] atan_deg(input logic [CNT_W-1:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			5'd0:  r = 23'd2949120;
			5'd1:  r = 23'd1740967;
			5'd2:  r = 23'd919879;
			5'd3:  r = 23'd466945;
			5'd4:  r = 23'd234379;
			5'd5:  r = 23'd117304;
			5'd6:  r = 23'd58666;
			5'd7:  r = 23'd29335;
			5'd8:  r = 23'd14668;
			5'd9:  r = 23'd7334;
			5'd10: r = 23'd3667;
			5'd11: r = 23'd1833;
			5'd12: r = 23'd917;
			5'd13: r = 23'd458;
			5'd14: r = 23'd229;
			5'd15: r = 23'd115;
			5'd16: r = 23'd57;
			5'd17: r = 23'd29;
			5'd18: r = 23'd14;
			5'd19: r = 23'd7;
			5'd20: r = 23'd4;
			5'd21: r = 23'd2;
			5'd22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/fcvu_if.sv
// fcvu channel interfaces: frame input, view row output and register write port
// depends on fcvu_pkg for the register index width

interface fcvu_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mouse_dx;
	logic signed [15:0] mouse_dy;
	logic [15:0]        frame_time;
	logic [3:0]         move_keys;
	modport source (output valid, mouse_dx, mouse_dy, frame_time, move_keys, input ready);
	modport sink (input valid, mouse_dx, mouse_dy, frame_time, move_keys, output ready);
endinterface

interface fcvu_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         row_index;
	logic signed [31:0] col_x;
	logic signed [31:0] col_y;
	logic signed [31:0] col_z;
	logic signed [31:0] col_w;
	logic               last_row;
	modport source (output valid, row_index, col_x, col_y, col_z, col_w, last_row,
		input ready);
	modport sink (input valid, row_index, col_x, col_y, col_z, col_w, last_row,
		output ready);
endinterface

interface fcvu_cfg_if import fcvu_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/fcvu_ctrl.sv
// fcvu_ctrl: sequencer that steps the datapath through angle update, trig and micro-program
// depends on fcvu_pkg for the command struct

module fcvu_ctrl import fcvu_pkg::*; #(
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_ANGLE, S_WRAP, S_CINIT, S_CITER, S_CSTORE, S_PROG, S_OUT
	} state_t;

	localparam logic [CNT_W-1:0] LAST_IT   = CNT_W'(TRIG_ITERATIONS - 1);
	localparam logic [CNT_W-1:0] LAST_UOP  = CNT_W'(PROG_LEN - 1);
	localparam logic [CNT_W-1:0] WRAP_TOP  = CNT_W'(WRAP_STEPS - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pitch_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_ANGLE;
				end
				S_ANGLE: begin
					cnt_q   <= WRAP_TOP;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (cnt_q == '0) begin
						pitch_q <= 1'b0;
						state_q <= S_CINIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_CINIT: begin
					cnt_q   <= '0;
					state_q <= S_CITER;
				end
				S_CITER: begin
					if (cnt_q == LAST_IT) state_q <= S_CSTORE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_CSTORE: begin
					if (pitch_q) begin
						cnt_q   <= '0;
						state_q <= S_PROG;
					end else begin
						pitch_q <= 1'b1;
						state_q <= S_CINIT;
					end
				end
				S_PROG: begin
					if (cnt_q == LAST_UOP) begin
						cnt_q   <= '0;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (cnt_q[1:0] == 2'd3) state_q <= S_IDLE;
						else cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		cmd.idx   = cnt_q;
		cmd.pitch = pitch_q;
		unique case (state_q)
			S_IDLE:   cmd.op = OP_LOAD;
			S_ANGLE:  cmd.op = OP_ANGLE;
			S_WRAP:   cmd.op = OP_WRAP;
			S_CINIT:  cmd.op = OP_CINIT;
			S_CITER:  cmd.op = OP_CITER;
			S_CSTORE: cmd.op = OP_CSTORE;
			S_PROG:   cmd.op = OP_PROG;
			S_OUT:    cmd.op = OP_OUT;
			default:  cmd.op = OP_LOAD;
		endcase
	end

endmodule

// File: sv/fcvu_datapath.sv
// fcvu_datapath: angle registers, shared cordic stage, shared multiplier, eye and row registers
// depends on fcvu_pkg for the command struct, micro-program and arctangent table

module fcvu_datapath import fcvu_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]          cfg_data,
	input  logic signed [15:0]   mouse_dx,
	input  logic signed [15:0]   mouse_dy,
	input  logic [15:0]          frame_time,
	input  logic [3:0]           move_keys,
	output logic [1:0]           row_index,
	output logic signed [31:0]   col_x,
	output logic signed [31:0]   col_y,
	output logic signed [31:0]   col_z,
	output logic signed [31:0]   col_w,
	output logic                 last_row
);

	localparam int AW = (VALUE_WIDTH > STEP_W) ? VALUE_WIDTH : STEP_W + 1;
	localparam int PW = AW + UNIT_W;
	localparam int TW = PW - 16;
	localparam int DW = AW + 4;
	localparam logic signed [DW-1:0] V_HI = DW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [DW-1:0] V_LO = -V_HI - 1;

	function automatic logic signed [VALUE_WIDTH-1:0] sat_v(input logic signed [DW-1:0] v);
		logic signed [VALUE_WIDTH-1:0] r;
		if (v > V_HI) r = V_HI[VALUE_WIDTH-1:0];
		else if (v < V_LO) r = V_LO[VALUE_WIDTH-1:0];
		else r = v[VALUE_WIDTH-1:0];
		return r;
	endfunction

	function automatic logic signed [DW-1:0] ext_u(input logic signed [UNIT_W-1:0] u);
		return {{(DW-UNIT_W){u[UNIT_W-1]}}, u};
	endfunction

	function automatic logic [31:0] to_out(input logic signed [VALUE_WIDTH-1:0] v);
		logic [63:0] e;
		e = {{(64-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
		return e[31:0];
	endfunction

	// configuration and captured frame
	logic [15:0]        sens_q, speed_q;
	logic signed [15:0] dx_q, dy_q;
	logic [15:0]        dt_q;
	logic [3:0]         keys_q;

	// kept camera state
	logic [YAW_W-1:0]          yaw_q;
	logic signed [PITCH_W-1:0] pitch_q;
	logic signed [VALUE_WIDTH-1:0] eye_q [3];

	// per-frame work registers
	logic [WORK_W-1:0]        work_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic                     flip_q;
	logic signed [UNIT_W-1:0] sy_q, cy_q, sp_q, cp_q, f0_q, f2_q, u0_q, u2_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [DW-1:0]     acc_q;
	logic signed [VALUE_WIDTH-1:0] w_q [3];

	// angle update
	logic signed [32:0]     dx_prod, dy_prod;
	logic [WORK_W-1:0]      yaw_sum;
	logic signed [WORK_W-1:0] p_sum;
	logic [31:0]            step_prod;
	logic [WORK_W-1:0]      wrap_thr;

	always_comb begin
		dx_prod   = dx_q * $signed({1'b0, sens_q});
		dy_prod   = dy_q * $signed({1'b0, sens_q});
		yaw_sum   = {{(WORK_W-YAW_W){1'b0}}, yaw_q} + {{(WORK_W-33){dx_prod[32]}}, dx_prod};
		p_sum     = $signed({{(WORK_W-PITCH_W){pitch_q[PITCH_W-1]}}, pitch_q})
			+ $signed({{(WORK_W-33){dy_prod[32]}}, dy_prod});
		step_prod = speed_q * dt_q;
		wrap_thr  = WORK_W'(DEG360) << cmd.idx[2:0];
	end

	// cordic stage
	logic signed [Z_W-1:0]  ang, ang_yaw;
	logic signed [XY_W-1:0] sh_x, sh_y, xs, ys;
	logic signed [Z_W-1:0]  at;
	logic signed [UNIT_W-1:0] s_cl, c_cl;

	always_comb begin
		ang_yaw = $signed({1'b0, yaw_q});
		if (ang_yaw > Z_W'(DEG180)) ang_yaw = ang_yaw - Z_W'(DEG360);
		ang = cmd.pitch ? {{(Z_W-PITCH_W){pitch_q[PITCH_W-1]}}, pitch_q} : ang_yaw;
		sh_x = x_q >>> cmd.idx;
		sh_y = y_q >>> cmd.idx;
		at   = $signed({{(Z_W-ATAN_W){1'b0}}, atan_deg(cmd.idx)});
		xs   = flip_q ? -x_q : x_q;
		ys   = flip_q ? -y_q : y_q;
		if (ys > XY_W'(ONE_Q)) s_cl = UNIT_W'(ONE_Q);
		else if (ys < -XY_W'(ONE_Q)) s_cl = -UNIT_W'(ONE_Q);
		else s_cl = ys[UNIT_W-1:0];
		if (xs > XY_W'(ONE_Q)) c_cl = UNIT_W'(ONE_Q);
		else if (xs < -XY_W'(ONE_Q)) c_cl = -UNIT_W'(ONE_Q);
		else c_cl = xs[UNIT_W-1:0];
	end

	// shared multiplier and write-back
	uop_t                     uop;
	logic signed [AW-1:0]     a_op;
	logic signed [UNIT_W-1:0] b_op;
	logic signed [TW-1:0]     term;
	logic signed [DW-1:0]     term_d, eye_ext, row_sum;

	always_comb begin
		uop = prog_uop(cmd.idx);
		unique case (uop.a)
			A_SY:    a_op = {{(AW-UNIT_W){sy_q[UNIT_W-1]}}, sy_q};
			A_CY:    a_op = {{(AW-UNIT_W){cy_q[UNIT_W-1]}}, cy_q};
			A_STEP:  a_op = {{(AW-STEP_W){1'b0}}, step_q};
			A_EYE0:  a_op = {{(AW-VALUE_WIDTH+1){eye_q[0][VALUE_WIDTH-1]}},
				eye_q[0][VALUE_WIDTH-2:0]};
			A_EYE1:  a_op = {{(AW-VALUE_WIDTH+1){eye_q[1][VALUE_WIDTH-1]}},
				eye_q[1][VALUE_WIDTH-2:0]};
			A_EYE2:  a_op = {{(AW-VALUE_WIDTH+1){eye_q[2][VALUE_WIDTH-1]}},
				eye_q[2][VALUE_WIDTH-2:0]};
			default: a_op = '0;
		endcase
		unique case (uop.b)
			B_CP:    b_op = cp_q;
			B_SP:    b_op = sp_q;
			B_F0:    b_op = f0_q;
			B_F1:    b_op = sp_q;
			B_F2:    b_op = f2_q;
			B_R0:    b_op = -sy_q;
			B_R1:    b_op = '0;
			B_R2:    b_op = cy_q;
			B_U0:    b_op = u0_q;
			B_U1:    b_op = cp_q;
			B_U2:    b_op = u2_q;
			default: b_op = '0;
		endcase
		// floor of the q16.16 product
		term    = prod_q[PW-1:16];
		term_d  = {{(DW-TW){term[TW-1]}}, term};
		eye_ext = {{(DW-VALUE_WIDTH){eye_q[uop.lane][VALUE_WIDTH-1]}}, eye_q[uop.lane]};
		row_sum = acc_q + term_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q   <= SENS_RESET;
			speed_q  <= SPEED_RESET;
			yaw_q    <= '0;
			pitch_q  <= '0;
			eye_q[0] <= '0;
			eye_q[1] <= '0;
			eye_q[2] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_LOOK_SENS) sens_q <= cfg_data;
				else if (cfg_idx == REG_MOVE_SPEED) speed_q <= cfg_data;
			end
			if (cmd.op == OP_ANGLE) begin
				if (p_sum > WORK_W'(PITCH_LIM)) pitch_q <= PITCH_W'(PITCH_LIM);
				else if (p_sum < -WORK_W'(PITCH_LIM)) pitch_q <= -PITCH_W'(PITCH_LIM);
				else pitch_q <= p_sum[PITCH_W-1:0];
			end
			if (cmd.op == OP_WRAP && cmd.idx == '0) begin
				yaw_q <= (work_q >= wrap_thr) ? YAW_W'(work_q - wrap_thr) : work_q[YAW_W-1:0];
			end
			if (cmd.op == OP_PROG && keys_q[uop.key]) begin
				if (uop.wb == WB_EYE_ADD) eye_q[uop.lane] <= sat_v(eye_ext + term_d);
				else if (uop.wb == WB_EYE_SUB) eye_q[uop.lane] <= sat_v(eye_ext - term_d);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				dx_q   <= mouse_dx;
				dy_q   <= mouse_dy;
				dt_q   <= frame_time;
				keys_q <= move_keys;
			end
			OP_ANGLE: begin
				work_q <= yaw_sum[WORK_W-1] ? yaw_sum + WORK_W'(WRAP_BIAS) : yaw_sum;
			end
			OP_WRAP: begin
				step_q <= step_prod[31:8];
				if (work_q >= wrap_thr) work_q <= work_q - wrap_thr;
			end
			OP_CINIT: begin
				x_q <= XY_W'(CORDIC_GAIN);
				y_q <= '0;
				if (ang > Z_W'(DEG90)) begin
					z_q    <= ang - Z_W'(DEG180);
					flip_q <= 1'b1;
				end else if (ang < -Z_W'(DEG90)) begin
					z_q    <= ang + Z_W'(DEG180);
					flip_q <= 1'b1;
				end else begin
					z_q    <= ang;
					flip_q <= 1'b0;
				end
			end
			OP_CITER: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - sh_y;
					y_q <= y_q + sh_x;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + sh_y;
					y_q <= y_q - sh_x;
					z_q <= z_q + at;
				end
			end
			OP_CSTORE: begin
				if (cmd.pitch) begin
					sp_q <= s_cl;
					cp_q <= c_cl;
				end else begin
					sy_q <= s_cl;
					cy_q <= c_cl;
				end
			end
			OP_PROG: begin
				prod_q <= a_op * b_op;
				unique case (uop.wb)
					WB_F0:       f0_q <= term[UNIT_W-1:0];
					WB_F2:       f2_q <= term[UNIT_W-1:0];
					WB_U0:       u0_q <= -term[UNIT_W-1:0];
					WB_U2:       u2_q <= -term[UNIT_W-1:0];
					WB_ACC_LOAD: acc_q <= term_d;
					WB_ACC_ADD:  acc_q <= row_sum;
					WB_ROW:      w_q[uop.lane] <= (uop.lane == 2'd2) ? sat_v(row_sum)
						: sat_v(-row_sum);
					default: ;
				endcase
			end
			OP_OUT: ;
			default: ;
		endcase
	end

	// row assembly
	logic signed [DW-1:0] ex, ey, ez, ew;

	always_comb begin
		row_index = cmd.idx[1:0];
		last_row  = (cmd.idx[1:0] == 2'd3);
		unique case (cmd.idx[1:0])
			2'd0: begin
				ex = ext_u(-sy_q);
				ey = '0;
				ez = ext_u(cy_q);
				ew = {{(DW-VALUE_WIDTH){w_q[0][VALUE_WIDTH-1]}}, w_q[0]};
			end
			2'd1: begin
				ex = ext_u(u0_q);
				ey = ext_u(cp_q);
				ez = ext_u(u2_q);
				ew = {{(DW-VALUE_WIDTH){w_q[1][VALUE_WIDTH-1]}}, w_q[1]};
			end
			2'd2: begin
				ex = ext_u(-f0_q);
				ey = ext_u(-sp_q);
				ez = ext_u(-f2_q);
				ew = {{(DW-VALUE_WIDTH){w_q[2][VALUE_WIDTH-1]}}, w_q[2]};
			end
			default: begin
				ex = '0;
				ey = '0;
				ez = '0;
				ew = DW'(ONE_Q);
			end
		endcase
		col_x = to_out(sat_v(ex));
		col_y = to_out(sat_v(ey));
		col_z = to_out(sat_v(ez));
		col_w = to_out(sat_v(ew));
	end

endmodule

// File: sv/fly_camera_view_update.sv
// the shared cordic stage, run once for yaw and once for pitch, and the single shared
// multiplier stepping through 26 micro-ops do the work of each frame; rows leave one per
// cycle while view.ready is high; no new frame is taken until the last row has left
// reset: arst_n clears yaw, pitch and eye position to zero and the registers to defaults

module fly_camera_view_update import fcvu_pkg::*; #(
	parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF,
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fcvu_in_if.sink    frame,
	fcvu_out_if.source view,
	fcvu_cfg_if.sink   cfg
);

	cmd_t cmd;
	logic in_ready;
	logic out_valid;

	// register writes never stall
	assign cfg.ready = 1'b1;

	// controller: one frame at a time, input taken only while idle
	fcvu_ctrl #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(view.ready),
		.cmd      (cmd)
	);

	assign frame.ready = in_ready;
	assign view.valid  = out_valid;

	// datapath: frame capture, angle wrap, cordic, micro-program and row mux
	fcvu_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.mouse_dx  (frame.mouse_dx),
		.mouse_dy  (frame.mouse_dy),
		.frame_time(frame.frame_time),
		.move_keys (frame.move_keys),
		.row_index (view.row_index),
		.col_x     (view.col_x),
		.col_y     (view.col_y),
		.col_z     (view.col_z),
		.col_w     (view.col_w),
		.last_row  (view.last_row)
	);

endmodule

// File: sv/fcvu_checker.sv
// fcvu_checker: port-level checks on frame/row ordering, bound to the top level
// depends only on the top level's ports

module fcvu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] row_index,
	input logic       last_row
);

	// never takes a frame while rows are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("frame taken while rows pending");

	a_no_row_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("row right after frame transfer");

	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (row_index == 2'd0))
		else $error("first row is not row 0");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_row) |=>
			(out_valid && row_index == $past(row_index) + 2'd1))
		else $error("rows out of order");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_row) |=> !out_valid)
		else $error("extra row after last");

endmodule

bind fly_camera_view_update fcvu_checker u_fcvu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (frame.valid),
	.in_ready (frame.ready),
	.out_valid(view.valid),
	.out_ready(view.ready),
	.row_index(view.row_index),
	.last_row (view.last_row)
);

// File: test/fly_camera_view_update_test.sv
// testbench for fly_camera_view_update: drives frames and register writes, checks view rows
// depends on fcvu_pkg, the fcvu channel interfaces and the block itself
`timescale 1ns / 100ps

module fly_camera_view_update_test;
	import fcvu_pkg::*;

	localparam int VW    = 32;
	localparam int NITER = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [1:0]         row;
		logic signed [31:0] x, y, z, w;
		logic               last;
	} view_row_t;

	// camera predictor with its own state and register copies
	class view_scoreboard;
		longint sens, speed;
		longint yaw, pitch;
		longint eye[3];
		view_row_t pending[$];
		int errors;

		function void clear();
			sens = SENS_RESET; speed = SPEED_RESET;
			yaw = 0; pitch = 0;
			eye[0] = 0; eye[1] = 0; eye[2] = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == REG_LOOK_SENS) sens = val;
			else if (idx == REG_MOVE_SPEED) speed = val;
		endfunction

		// product floored toward minus infinity
		function longint qmul(longint a, longint b);
			longint p;
			p = a * b;
			return p >>> 16;
		endfunction

		function longint sat(longint v);
			longint hi, lo;
			hi = (longint'(1) <<< (VW - 1)) - 1;
			lo = -hi - 1;
			return v > hi ? hi : (v < lo ? lo : v);
		endfunction

		function longint unit(longint v);
			return v > ONE_Q ? ONE_Q : (v < -ONE_Q ? -ONE_Q : v);
		endfunction

		function void trig(longint ang, output longint s, output longint c);
			longint atans[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
			longint x, y, z, dx, dy, at;
			bit flip;
			flip = 0; x = CORDIC_GAIN; y = 0;
			if (ang > DEG90) begin
				ang -= DEG180; flip = 1;
			end else if (ang < -DEG90) begin
				ang += DEG180; flip = 1;
			end
			z = ang;
			for (int i = 0; i < NITER && i < 32; i++) begin
				dx = y >>> i; dy = x >>> i;
				at = i < 23 ? atans[i] : 0;
				if (z >= 0) begin
					x -= dx; y += dy; z -= at;
				end else begin
					x += dx; y -= dy; z += at;
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			s = unit(y); c = unit(x);
		endfunction

		function void nudge(longint d[3], longint step, bit add);
			for (int k = 0; k < 3; k++)
				eye[k] = sat(add ? eye[k] + qmul(step, d[k]) : eye[k] - qmul(step, d[k]));
		endfunction

		function longint eye_dot(longint v[3]);
			return qmul(eye[0], v[0]) + qmul(eye[1], v[1]) + qmul(eye[2], v[2]);
		endfunction

		// a frame transfer: advance the camera and queue four rows
		function void note_frame(logic signed [15:0] mdx, logic signed [15:0] mdy,
				logic [15:0] dt, logic [3:0] keys);
			longint sy, cy, sp, cp, step;
			longint f[3], r[3], u[3], m[4][4];
			view_row_t e;
			yaw = (yaw + longint'(mdx) * sens) % DEG360;
			if (yaw < 0) yaw += DEG360;
			pitch += longint'(mdy) * sens;
			if (pitch > PITCH_LIM) pitch = PITCH_LIM;
			if (pitch < -PITCH_LIM) pitch = -PITCH_LIM;
			trig(yaw > DEG180 ? yaw - DEG360 : yaw, sy, cy);
			trig(pitch, sp, cp);
			f = '{qmul(cy, cp), sp, qmul(sy, cp)};
			r = '{-sy, 0, cy};
			u = '{-qmul(cy, sp), cp, -qmul(sy, sp)};
			step = (speed * longint'(dt)) >>> 8;
			if (keys[0]) nudge(f, step, 1);
			if (keys[1]) nudge(f, step, 0);
			if (keys[2]) nudge(r, step, 0);
			if (keys[3]) nudge(r, step, 1);
			for (int j = 0; j < 3; j++) begin
				m[0][j] = r[j]; m[1][j] = u[j]; m[2][j] = -f[j]; m[3][j] = 0;
			end
			m[0][3] = sat(-eye_dot(r));
			m[1][3] = sat(-eye_dot(u));
			m[2][3] = sat(eye_dot(f));
			m[3][3] = ONE_Q;
			for (int k = 0; k < 4; k++) begin
				e.row = 2'(k);
				e.x = 32'(sat(m[k][0])); e.y = 32'(sat(m[k][1]));
				e.z = 32'(sat(m[k][2])); e.w = 32'(sat(m[k][3]));
				e.last = (k == 3);
				pending.push_back(e);
			end
		endfunction

		function void report(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
			errors++;
		endfunction

		function void check_row(view_row_t g);
			view_row_t e;
			if (pending.size() == 0) begin
				report("row with nothing pending, row_index", g.row, 0);
				return;
			end
			e = pending.pop_front();
			if (g.row !== e.row) report("row_index", g.row, e.row);
			if (g.x !== e.x) report("col_x", g.x, e.x);
			if (g.y !== e.y) report("col_y", g.y, e.y);
			if (g.z !== e.z) report("col_z", g.z, e.z);
			if (g.w !== e.w) report("col_w", g.w, e.w);
			if (g.last !== e.last) report("last_row", g.last, e.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fcvu_in_if  frame();
	fcvu_out_if view();
	fcvu_cfg_if cfg();

	fly_camera_view_update uut (
		.clk(clk), .arst_n(arst_n), .frame(frame.sink), .view(view.source), .cfg(cfg.sink)
	);

	view_scoreboard sb;
	bit quiet;      // long stretch with no idling on either side
	int idle_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// output side: random backpressure, check at the rising edge
	initial begin
		view.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && view.valid && view.ready) begin
				view_row_t g;
				g.row = view.row_index; g.x = view.col_x; g.y = view.col_y;
				g.z = view.col_z; g.w = view.col_w; g.last = view.last_row;
				sb.check_row(g);
			end
			@(negedge clk);
			view.ready <= quiet || ($urandom_range(99) >= 17);
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((frame.valid && frame.ready) || (view.valid && view.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_frame(logic signed [15:0] mdx, logic signed [15:0] mdy,
			logic [15:0] dt, logic [3:0] keys);
		while (!quiet && $urandom_range(99) < 17) @(negedge clk);
		frame.valid <= 1;
		frame.mouse_dx <= mdx; frame.mouse_dy <= mdy;
		frame.frame_time <= dt; frame.move_keys <= keys;
		do @(posedge clk); while (!frame.ready);
		sb.note_frame(mdx, mdy, dt, keys);
		@(negedge clk);
		frame.valid = 0;
	endtask

	task automatic send_random_frame();
		logic signed [15:0] mdx, mdy;
		case ($urandom_range(3))
			0: begin
				mdx = 16'($urandom); mdy = 16'($urandom);
			end
			default: begin
				mdx = 16'($signed(16'($urandom_range(400))) - 200);
				mdy = 16'($signed(16'($urandom_range(200))) - 100);
			end
		endcase
		send_frame(mdx, mdy, 16'($urandom), 4'($urandom_range(15)));
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	initial begin
		sb = new();
		sb.clear();
		quiet = 0;
		frame.valid = 0; frame.mouse_dx = 0; frame.mouse_dy = 0;
		frame.frame_time = 0; frame.move_keys = 0;
		cfg.valid = 0; cfg.index = REG_LOOK_SENS; cfg.data = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: defaults, extremes of offsets, pitch limits, yaw wrap, every key
		send_frame(0, 0, 0, 4'h0);
		send_frame(16'sh7fff, 0, 16'hffff, 4'h1);
		send_frame(-16'sh8000, 0, 16'hffff, 4'h2);
		send_frame(0, 16'sh7fff, 16'h8000, 4'h4);
		send_frame(0, -16'sh8000, 16'h8000, 4'h8);
		send_frame(900, 450, 16'h1000, 4'h3);
		send_frame(-1800, -900, 16'h1000, 4'hc);
		send_frame(1, -1, 16'hffff, 4'hf);
		send_frame(3600, 0, 16'h0001, 4'h5);
		drain();

		// biggest speed and sensitivity: pitch runs into its limit, the eye steps at full speed
		write_reg(REG_LOOK_SENS, 16'hffff);
		write_reg(REG_MOVE_SPEED, 16'hffff);
		for (int i = 0; i < 12; i++)
			send_frame(16'sh7fff, 16'sh7fff, 16'hffff, (i < 8) ? 4'h1 : 4'h8);
		drain();

		// random phases through several register settings, zeros among them
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					write_reg(REG_LOOK_SENS, 16'd0);
					write_reg(REG_MOVE_SPEED, 16'd0);
				end
				1: begin
					write_reg(REG_LOOK_SENS, SENS_RESET);
					write_reg(REG_MOVE_SPEED, SPEED_RESET);
				end
				default: begin
					write_reg(REG_LOOK_SENS, 16'($urandom));
					write_reg(REG_MOVE_SPEED, 16'($urandom));
				end
			endcase
			quiet = (p == 2);
			for (int i = 0; i < 80; i++) begin
				send_random_frame();
				// pause until every row is back
				if (i == 40) while (sb.pending.size() != 0) @(negedge clk);
			end
			quiet = 0;
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
sv/fcvu_pkg.sv
sv/fcvu_if.sv
sv/fcvu_ctrl.sv
sv/fcvu_datapath.sv
sv/fly_camera_view_update.sv
sv/fcvu_checker.sv
test/fly_camera_view_update_test.sv
